[src/rrdes_pkg.sv]
`timescale 1ns / 1ps
// Shared types, DES tables and bit permutation functions for the reduced-round cipher.
// Used by rrdes_feistel and reduced_round_des_cipher; depends on nothing.
package rrdes_pkg;

  localparam int MAX_ROUNDS_DEF = 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } rrdes_state_t;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY    = 2'd0;
  localparam logic [1:0] REG_ROUNDS = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  // Bit 1 of each table entry is the MSB of the source word.
  function automatic logic [63:0] perm_ip(logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[6'(7'd64 - IP_TAB[i])];
    return y;
  endfunction

  function automatic logic [63:0] perm_fp(logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[6'(7'd64 - FP_TAB[i])];
    return y;
  endfunction

  function automatic logic [47:0] perm_e(logic [31:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) y[47-i] = x[5'(6'd32 - E_TAB[i])];
    return y;
  endfunction

  function automatic logic [31:0] perm_p(logic [31:0] x);
    logic [31:0] y;
    for (int i = 0; i < 32; i++) y[31-i] = x[5'(6'd32 - P_TAB[i])];
    return y;
  endfunction

  function automatic logic [55:0] perm_pc1(logic [63:0] x);
    logic [55:0] y;
    for (int i = 0; i < 56; i++) y[55-i] = x[6'(7'd64 - PC1_TAB[i])];
    return y;
  endfunction

  function automatic logic [47:0] perm_pc2(logic [55:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) y[47-i] = x[6'(6'd56 - PC2_TAB[i])];
    return y;
  endfunction

  // Total left rotation of the key halves for round key idx (0-based), mod 28.
  function automatic logic [4:0] key_shift(logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:    s = 5'd1;
      4'd1:    s = 5'd2;
      4'd2:    s = 5'd4;
      4'd3:    s = 5'd6;
      4'd4:    s = 5'd8;
      4'd5:    s = 5'd10;
      4'd6:    s = 5'd12;
      4'd7:    s = 5'd14;
      4'd8:    s = 5'd15;
      4'd9:    s = 5'd17;
      4'd10:   s = 5'd19;
      4'd11:   s = 5'd21;
      4'd12:   s = 5'd23;
      4'd13:   s = 5'd25;
      4'd14:   s = 5'd27;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [27:0] rotl28(logic [27:0] v, logic [4:0] s);
    logic [55:0] t;
    t = {v, v} << s;
    return t[55:28];
  endfunction

endpackage

[src/rrdes_feistel.sv]
`timescale 1ns / 1ps
// DES round function f(R, K): expansion, key mix, S-boxes and P permutation.
// Depends on rrdes_pkg for the tables and permutations.
module rrdes_feistel import rrdes_pkg::*; (
  input  logic [31:0] r,
  input  logic [47:0] subkey,
  output logic [31:0] f
);

  logic [47:0] x;
  logic [31:0] s;
  logic [5:0]  b;

  assign x = perm_e(r) ^ subkey;

  always_comb begin
    s = '0;
    b = '0;
    for (int j = 0; j < 8; j++) begin
      b = x[47 - 6*j -: 6];
      // row is the outer bit pair, column the middle four bits
      s[31 - 4*j -: 4] = SBOX[j][{b[5], b[0], b[4:1]}];
    end
  end

  assign f = perm_p(s);

endmodule

[src/reduced_round_des_cipher.sv]
`timescale 1ns / 1ps
// Top level of the reduced-round DES cipher: configuration registers, round sequencer,
// shared round datapath and output register. Depends on rrdes_pkg and rrdes_feistel.
//
// Usage:
//   Input channel: block_in with in_valid / in_stall. An item is taken when in_valid is
//   high and in_stall low. in_stall is high while a block is being worked on.
//   Output channel: block_out with out_valid / out_stall, from an output register.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 key, 1 round
//   count, 2 decrypt mode); write only while the block is idle.
//   Timing: the accept cycle applies IP and PC-1, then one Feistel round per cycle
//   through the single round unit, with the round key made on the fly by rotating the
//   stored key halves by the cumulative shift of that round and applying PC-2.
//   With n effective rounds (round count clamped to 1..MAX_ROUNDS), block_out is
//   loaded from the final halves after the last round, and a new item is taken only
//   once the previous block has left the round datapath for the output register.
//   Stall: a waiting result does not block the next accept. If a block finishes while
//   the previous result is still stalled, its final halves are held until the output
//   register frees up.
//   Reset: clears the handshake state and sets key 0, round count 16, encrypt mode.
module reduced_round_des_cipher import rrdes_pkg::*; #(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] block_in,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [63:0] block_out,
  output logic        out_valid,
  input  logic        out_stall,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

  logic [63:0] cipher_key;
  logic [4:0]  round_count;
  logic        decrypt_mode;

  rrdes_state_t state, state_next;

  logic [31:0]   l, r;
  logic [27:0]   c0, d0;
  logic [RW-1:0] k, left;
  logic          dir;

  logic [4:0]  nr_m1;
  logic [4:0]  shift;
  logic [47:0] subkey;
  logic [31:0] f;
  logic [63:0] fin_blk;
  logic        accept, last, out_free, load_out, round_en;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key   <= '0;
      round_count  <= 5'd16;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY:    cipher_key   <= cfg_data;
        REG_ROUNDS: round_count  <= cfg_data[4:0];
        REG_MODE:   decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp round count to 1..MAX_ROUNDS, kept as count minus one
  always_comb begin
    if (round_count == 5'd0) begin
      nr_m1 = 5'd0;
    end else if (round_count > 5'(MAX_ROUNDS)) begin
      nr_m1 = 5'(MAX_ROUNDS - 1);
    end else begin
      nr_m1 = round_count - 5'd1;
    end
  end

  // ---------------- sequencer ----------------
  assign accept   = in_valid && !in_stall;
  assign last     = (left == '0);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_RUN;
      end
      S_RUN: begin
        if (last) state_next = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    round_en = 1'b0;
    load_out = 1'b0;
    case (state)
      // hold off the sender while reset is applied
      S_IDLE: in_stall = rst;
      S_RUN: begin
        round_en = 1'b1;
        load_out = last && out_free;
      end
      S_HOLD: load_out = out_free;
      default: ;
    endcase
  end

  // ---------------- round datapath ----------------
  assign shift  = key_shift(4'(k));
  assign subkey = perm_pc2({rotl28(c0, shift), rotl28(d0, shift)});

  rrdes_feistel u_feistel (
    .r      (r),
    .subkey (subkey),
    .f      (f)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      {l, r}   <= perm_ip(block_in);
      {c0, d0} <= perm_pc1(cipher_key);
      k        <= decrypt_mode ? nr_m1[RW-1:0] : '0;
      left     <= nr_m1[RW-1:0];
      dir      <= decrypt_mode;
    end else if (round_en) begin
      if (last) begin
        // no half swap after the final round
        l <= l ^ f;
      end else begin
        l    <= r;
        r    <= l ^ f;
        k    <= dir ? (k - RW'(1)) : (k + RW'(1));
        left <= left - RW'(1);
      end
    end
  end

  // ---------------- output register ----------------
  assign fin_blk = (state == S_RUN) ? {l ^ f, r} : {l, r};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) block_out <= perm_fp(fin_blk);
  end

  // ---------------- assertions ----------------
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RUN)
    else $error("accepted item did not start the round sequence");

  a_hold_has_output: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD |-> out_valid)
    else $error("finished block held without a pending result");

  a_decrypt_key_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && dir) |-> k == left)
    else $error("decrypt key index out of step with round counter");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("output load did not raise out_valid");

endmodule
